>>> design/smm_pkg.sv
// Package for the square matrix multiplier: word type, pipeline tag and
// controller state encoding. No dependencies.
package smm_pkg;

    localparam int WORD_W = 32;

    typedef logic [WORD_W-1:0] t_word;

    // controller states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // tag that travels with one product term down the MAC pipeline
    typedef struct packed {
        logic vld;     // term present
        logic first;   // first term of a dot product
        logic dot_end; // last term of a dot product
        logic fin;     // last term of the whole matrix
    } t_tag;

endpackage

>>> design/smm_store.sv
// Operand store of the square matrix multiplier: two synchronous memories
// (A and B) with one write port and one registered read port each.
// Depends on smm_pkg.
module smm_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  smm_pkg::t_word  i_wr_a,
    input  smm_pkg::t_word  i_wr_b,
    input  logic [AW-1:0]   i_rd_addr_a,
    input  logic [AW-1:0]   i_rd_addr_b,
    output smm_pkg::t_word  o_rd_a,
    output smm_pkg::t_word  o_rd_b
);
    import smm_pkg::*;

    t_word r_mem_a [DEPTH];
    t_word r_mem_b [DEPTH];

    // write port, shared address for both matrices
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_a[i_wr_addr] <= i_wr_a;
            r_mem_b[i_wr_addr] <= i_wr_b;
        end
    end

    // read ports, registered
    always_ff @(posedge i_clk) begin
        o_rd_a <= r_mem_a[i_rd_addr_a];
        o_rd_b <= r_mem_b[i_rd_addr_b];
    end

endmodule

>>> design/square_matrix_multiply.sv
// Top level of the square matrix multiplier: load sequencer, address
// generator and multiply-accumulate pipeline. Depends on smm_pkg, smm_store.
//
// Usage:
//   Requests: drive i_a_element / i_b_element with start high; a request is
//   taken at a rising edge where start is high and busy is low. Requests
//   fill A and B in row-major order, one per cycle while busy is low.
//   The request that fills position DIM*DIM-1 starts the product C = A*B.
//   Results: o_strobe marks one element of C on o_product_element for one
//   cycle, row-major order, o_last_element high on the final one. There is
//   no backpressure on results.
//   Timing: one shared multiplier does DIM^3 products, one per cycle, the
//   operands coming from the two store memories. After the last load
//   request busy stays high; it falls in the cycle the final result is
//   shown. No new matrix pair is taken until then.
//   Reset: synchronous, active low; clears the load position and the
//   controller. Store contents are not cleared; every entry is written
//   before a product reads it.
module square_matrix_multiply #(
    parameter int DIM = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  smm_pkg::t_word  i_a_element,
    input  smm_pkg::t_word  i_b_element,
    output logic            o_strobe,
    output smm_pkg::t_word  o_product_element,
    output logic            o_last_element
);
    import smm_pkg::*;

    localparam int CELLS = DIM * DIM;
    localparam int AW    = $clog2(CELLS);
    localparam int IW    = $clog2(DIM);

    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [IW-1:0] LAST_IDX  = IW'(DIM - 1);
    localparam logic [AW-1:0] ROW_STEP  = AW'(DIM);

    t_state r_state, n_state;

    logic [AW-1:0] r_load_pos;
    logic [IW-1:0] r_row, r_col, r_t;
    logic [AW-1:0] r_a_base;   // row * DIM
    logic [AW-1:0] r_a_addr;   // row * DIM + t
    logic [AW-1:0] r_b_addr;   // t * DIM + col

    t_tag  r_s1_tag, r_s2_tag, n_s1_tag;
    t_word w_rd_a, w_rd_b;
    t_word r_prod, r_acc, w_sum;
    logic [2*WORD_W-1:0] w_full;

    logic w_accept, w_load_done, w_issue, w_issue_end;
    logic w_t_end, w_col_end, w_row_end;

    assign w_accept    = start && !busy;
    assign w_load_done = w_accept && (r_load_pos == LAST_CELL);

    assign w_t_end     = (r_t == LAST_IDX);
    assign w_col_end   = (r_col == LAST_IDX);
    assign w_row_end   = (r_row == LAST_IDX);
    assign w_issue_end = w_t_end && w_col_end && w_row_end;

    // operand memories
    smm_store #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (w_accept),
        .i_wr_addr   (r_load_pos),
        .i_wr_a      (i_a_element),
        .i_wr_b      (i_b_element),
        .i_rd_addr_a (r_a_addr),
        .i_rd_addr_b (r_b_addr),
        .o_rd_a      (w_rd_a),
        .o_rd_b      (w_rd_b)
    );

    // controller next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD:  if (w_load_done) n_state = ST_RUN;
            ST_RUN:   if (w_issue_end) n_state = ST_DRAIN;
            ST_DRAIN: if (r_s2_tag.vld && r_s2_tag.fin) n_state = ST_LOAD;
            default:  n_state = ST_LOAD;
        endcase
    end

    // controller outputs
    always_comb begin
        busy    = 1'b1;
        w_issue = 1'b0;
        unique case (r_state)
            ST_LOAD:  busy = 1'b0;
            ST_RUN:   w_issue = 1'b1;
            ST_DRAIN: busy = 1'b1;
            default:  busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // load position, wraps after the last cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_pos <= '0;
        end else if (w_accept) begin
            r_load_pos <= w_load_done ? '0 : r_load_pos + AW'(1);
        end
    end

    // index counters and read addresses, zeroed whenever no term is issued (load and drain)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || !w_issue) begin
            r_row    <= '0;
            r_col    <= '0;
            r_t      <= '0;
            r_a_base <= '0;
            r_a_addr <= '0;
            r_b_addr <= '0;
        end else if (!w_t_end) begin
            r_t      <= r_t + IW'(1);
            r_a_addr <= r_a_addr + AW'(1);
            r_b_addr <= r_b_addr + ROW_STEP;
        end else if (!w_col_end) begin
            r_t      <= '0;
            r_col    <= r_col + IW'(1);
            r_a_addr <= r_a_base;
            r_b_addr <= AW'(r_col) + AW'(1);
        end else begin
            r_t      <= '0;
            r_col    <= '0;
            r_row    <= r_row + IW'(1);
            r_a_base <= r_a_base + ROW_STEP;
            r_a_addr <= r_a_base + ROW_STEP;
            r_b_addr <= '0;
        end
    end

    // tag for the term whose operands are read this cycle
    always_comb begin
        n_s1_tag.vld     = w_issue;
        n_s1_tag.first   = (r_t == '0);
        n_s1_tag.dot_end = w_t_end;
        n_s1_tag.fin     = w_issue_end;
    end

    // pipeline tags: s1 = memory data, s2 = product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag <= '0;
            r_s2_tag <= '0;
        end else begin
            r_s1_tag <= n_s1_tag;
            r_s2_tag <= r_s1_tag;
        end
    end

    // multiply, low word only
    assign w_full = w_rd_a * w_rd_b;

    always_ff @(posedge i_clk) begin
        r_prod <= w_full[WORD_W-1:0];
    end

    // accumulate, restarting on the first term of each dot product
    assign w_sum = (r_s2_tag.first ? '0 : r_acc) + r_prod;

    always_ff @(posedge i_clk) begin
        if (r_s2_tag.vld) begin
            r_acc <= w_sum;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe       <= 1'b0;
            o_last_element <= 1'b0;
        end else begin
            o_strobe       <= r_s2_tag.vld && r_s2_tag.dot_end;
            o_last_element <= r_s2_tag.vld && r_s2_tag.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_tag.vld && r_s2_tag.dot_end) begin
            o_product_element <= w_sum;
        end
    end

endmodule

>>> tb/tb_square_matrix_multiply.sv
// Self-checking testbench for square_matrix_multiply: loads matrix pairs through
// the start/busy request port and checks every product element it streams out.
// Depends on smm_pkg and the square_matrix_multiply RTL.
`timescale 1ns / 1ps

module tb_square_matrix_multiply;
    import smm_pkg::*;

    localparam int DIM         = 8;
    localparam int CELLS       = DIM * DIM;
    localparam int MATRICES    = 4;
    localparam int STALL_LIMIT = 4 * DIM * DIM * DIM + 200;

    localparam t_word WORD_MAX = 32'h7FFF_FFFF;
    localparam t_word WORD_MIN = 32'h8000_0000;

    // how the elements of one matrix pair are chosen
    typedef enum int {
        FILL_DIRECTED,
        FILL_RANDOM,
        FILL_SMALL,
        FILL_CORNER,
        FILL_SPARSE
    } t_fill_mode;

    typedef struct packed {
        t_word value;
        logic  last;
    } t_product_entry;

    // Mirrors the two stores, predicts C = A*B on the last load request and
    // checks the streamed elements in order.
    class t_product_tracker;
        t_word          a_cells[CELLS];
        t_word          b_cells[CELLS];
        int             load_pos;
        int             errors;
        int             requests;
        int             products;
        int             matrices;
        t_product_entry pending_products[$];

        function new();
            load_pos = 0;
            errors   = 0;
            requests = 0;
            products = 0;
            matrices = 0;
        endfunction

        function void note_load(t_word a, t_word b);
            t_word          acc;
            t_product_entry entry;
            a_cells[load_pos] = a;
            b_cells[load_pos] = b;
            requests++;
            load_pos++;
            if (load_pos < CELLS) return;
            load_pos = 0;
            matrices++;
            // plain row-column dot products, wrapping at 32 bits
            for (int r = 0; r < DIM; r++) begin
                for (int c = 0; c < DIM; c++) begin
                    acc = '0;
                    for (int k = 0; k < DIM; k++) begin
                        acc = acc + a_cells[r*DIM + k] * b_cells[k*DIM + c];
                    end
                    entry.value = acc;
                    entry.last  = (r == DIM - 1) && (c == DIM - 1);
                    pending_products.push_back(entry);
                end
            end
        endfunction

        function void check_element(t_word value, logic last_flag);
            t_product_entry want;
            if (pending_products.size() == 0) begin
                errors++;
                $display("%0t: unexpected product element: expected none, actual %h (last %b)",
                         $time, value, last_flag);
                return;
            end
            want = pending_products.pop_front();
            products++;
            if (value !== want.value) begin
                errors++;
                $display("%0t: product element %0d: expected %h, actual %h",
                         $time, products - 1, want.value, value);
            end
            if (last_flag !== want.last) begin
                errors++;
                $display("%0t: last flag on element %0d: expected %b, actual %b",
                         $time, products - 1, want.last, last_flag);
            end
        endfunction

        function int outstanding();
            return pending_products.size();
        endfunction
    endclass

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_word i_a_element;
    t_word i_b_element;
    logic  o_strobe;
    t_word o_product_element;
    logic  o_last_element;

    t_product_tracker tracker;
    int               idle_cycles;

    square_matrix_multiply #(
        .DIM(DIM)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_a_element      (i_a_element),
        .i_b_element      (i_b_element),
        .o_strobe         (o_strobe),
        .o_product_element(o_product_element),
        .o_last_element   (o_last_element)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // observe accepted requests and result strobes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) tracker.note_load(i_a_element, i_b_element);
            if (o_strobe) tracker.check_element(o_product_element, o_last_element);
        end
    end

    // watchdog: too long without any request or result moving
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("** square_matrix_multiply: FAILED **");
            $finish;
        end
    end

    function t_word corner_value();
        case ($urandom_range(0, 6))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return '1;
            4:       return 32'd1;
            5:       return WORD_MIN + 32'd1;
            default: return $urandom;
        endcase
    endfunction

    // element pair for one row-major position
    function void make_element(t_fill_mode mode, int pos, output t_word a, output t_word b);
        a = $urandom;
        b = $urandom;
        case (mode)
            FILL_DIRECTED: begin
                case (pos)
                    0:  begin a = WORD_MAX;       b = WORD_MAX;       end
                    1:  begin a = WORD_MIN;       b = WORD_MIN;       end
                    2:  begin a = WORD_MAX;       b = WORD_MIN;       end
                    3:  begin a = WORD_MIN;       b = WORD_MAX;       end
                    4:  begin a = '0;             b = '1;             end
                    5:  begin a = '1;             b = '0;             end
                    6:  begin a = '1;             b = '1;             end
                    7:  begin a = 32'd1;          b = 32'd1;          end
                    8:  begin a = 32'd1;          b = '1;             end
                    9:  begin a = 32'h5555_5555;  b = 32'hAAAA_AAAA;  end
                    10: begin a = 32'hAAAA_AAAA;  b = 32'h5555_5555;  end
                    11: begin a = 32'h0000_FFFF;  b = 32'hFFFF_0000;  end
                    12: begin a = 32'hFFFF_0000;  b = 32'h0000_FFFF;  end
                    13: begin a = 32'h8000_0001;  b = 32'h7FFF_FFFE;  end
                    14: begin a = 32'h0001_0000;  b = 32'h0001_0000;  end
                    15: begin a = 32'd2;          b = WORD_MIN;       end
                    16: begin a = '0;             b = '0;             end
                    17: begin a = WORD_MAX;       b = 32'd2;          end
                    default: ;
                endcase
            end
            FILL_SMALL: begin
                a = $urandom_range(0, 16) - 8;
                b = $urandom_range(0, 16) - 8;
            end
            FILL_CORNER: begin
                a = corner_value();
                b = corner_value();
            end
            FILL_SPARSE: begin
                if ($urandom_range(0, 3) != 0) a = '0;
                if ($urandom_range(0, 3) != 0) b = corner_value();
            end
            default: ;
        endcase
    endfunction

    // hold one request until the block takes it; start stays high afterwards
    task automatic send_request(t_word a, t_word b);
        start       <= 1'b1;
        i_a_element <= a;
        i_b_element <= b;
        do @(posedge i_clk); while (busy);
    endtask

    // sender gap: start low, junk on the data ports
    task automatic hold_off(int cycles);
        start       <= 1'b0;
        i_a_element <= $urandom;
        i_b_element <= $urandom;
        repeat (cycles) @(posedge i_clk);
    endtask

    // sample at the falling edge so the count is settled, then realign
    task automatic wait_for_products();
        start <= 1'b0;
        @(negedge i_clk);
        while (tracker.outstanding() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        t_fill_mode mode;
        t_word      a_val;
        t_word      b_val;
        int         burst_left;
        bit         gaps_on;

        tracker     = new();
        idle_cycles = 0;
        burst_left  = 0;
        start       <= 1'b0;
        i_rst_n     <= 1'b0;
        i_a_element <= '0;
        i_b_element <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int m = 0; m < MATRICES; m++) begin
            // first pair directed, second full random, then a mix
            if (m == 0) mode = FILL_DIRECTED;
            else if (m == 1) mode = FILL_RANDOM;
            else mode = t_fill_mode'($urandom_range(FILL_RANDOM, FILL_SPARSE));
            // one pair is loaded back to back
            gaps_on = (m != 2);
            for (int pos = 0; pos < CELLS; pos++) begin
                make_element(mode, pos, a_val, b_val);
                if (gaps_on && burst_left == 0) begin
                    hold_off($urandom_range(1, 15));
                    burst_left = $urandom_range(1, 24);
                end
                send_request(a_val, b_val);
                if (burst_left > 0) burst_left--;
            end
            // let one product drain completely before loading more
            if (m == 1) wait_for_products();
        end

        wait_for_products();
        repeat (4 * DIM) @(posedge i_clk);

        $display("Loaded %0d matrix pairs (%0d requests, directed corners and random fills),",
                 tracker.matrices, tracker.requests);
        $display("checked %0d product elements with random request gaps.", tracker.products);
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("** square_matrix_multiply: PASSED **");
        end else begin
            $display("** square_matrix_multiply: FAILED **");
        end
        $finish;
    end

endmodule

>>> sim.f
design/smm_pkg.sv
design/smm_store.sv
design/square_matrix_multiply.sv
tb/tb_square_matrix_multiply.sv
